/* hw/rtl/vssm_pkg.sv */
// Shared types, constants and helpers for the VDIF stream second monitor.
`default_nettype none
package vssm_pkg;

    localparam int unsigned MAX_PACKET_BYTES_DEF = 65507;

    localparam logic [29:0] SEC_MASK    = 30'h3FFF_FFFF;
    localparam logic [24:0] FCNT_MAX    = 25'h1FF_FFFF;
    localparam logic [39:0] BCNT_MAX    = 40'hFF_FFFF_FFFF;
    localparam logic [15:0] VDIF_HDR_BYTES   = 16'd32;
    localparam logic [15:0] LEGACY_HDR_BYTES = 16'd16;
    localparam logic [10:0] BASE_YEAR   = 11'd2000;

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_BIG_ENDIAN    = 2'd0;
    localparam logic [1:0] CFG_OFFSET_BYTES  = 2'd1;
    localparam logic [1:0] CFG_FILTER_ENABLE = 2'd2;
    localparam logic [1:0] CFG_THREAD_SELECT = 2'd3;

    // Reciprocals for the constant divisions of the timestamp split.
    // seconds/86400 = ((seconds >> 7) * DAY_RECIP) >> 33, exact below 2^30
    localparam logic [23:0] DAY_RECIP   = 24'd12725830;
    localparam int unsigned DAY_SHIFT   = 33;
    // rem/3600 = ((rem >> 4) * HOUR_RECIP) >> 21, exact below 86400
    localparam logic [13:0] HOUR_RECIP  = 14'd9321;
    localparam int unsigned HOUR_SHIFT  = 21;
    // rem/60 = ((rem >> 2) * MIN_RECIP) >> 14, exact below 3600
    localparam logic [10:0] MIN_RECIP   = 11'd1093;
    localparam int unsigned MIN_SHIFT   = 14;

    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
    localparam logic [13:0] HALF_YEAR_DAYS      = 14'd181;
    localparam logic [13:0] HALF_LEAP_YEAR_DAYS = 14'd182;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_TIMEOUT,
        OP_FRAME,
        OP_THREAD
    } op_kind_t;

    // Classified item handed from front to back
    typedef struct packed {
        op_kind_t    kind;
        logic [29:0] sec;
        logic [23:0] fno;
        logic [5:0]  epoch;
        logic [5:0]  tid;
        logic [15:0] pay;
        logic [15:0] last_pay;
    } op_t;

    // Result record moving down the timestamp pipeline
    typedef struct packed {
        logic [29:0] sec;
        logic [5:0]  epoch;
        logic [23:0] fno;
        logic [24:0] frames;
        logic [24:0] max_fno_p1;
        logic [5:0]  threads;
        logic [39:0] bytes;
        logic [15:0] last_pay;
        logic [13:0] days;
        logic [16:0] rem_day;
        logic [13:0] doy;
        logic [4:0]  hh;
        logic [11:0] rem_hour;
        logic [5:0]  mm;
        logic [5:0]  ss;
    } rec_t;

    typedef struct packed {
        logic big_endian;
        logic [9:0] offset;
        logic filter_en;
        logic [5:0] thread_sel;
    } cfg_t;

    function automatic logic [31:0] swap32(input logic [31:0] w);
        swap32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/vssm_front.sv */
// Front end: configuration registers, input register and item classification.
`default_nettype none
module vssm_front
    import vssm_pkg::*;
#(
    parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [9:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic [15:0] packet_length,
    input  wire logic [31:0] header_word0,
    input  wire logic [31:0] header_word1,
    input  wire logic [31:0] header_word3,
    output logic             op_valid,
    input  wire logic        op_ready,
    output op_t              op
);

    cfg_t cfg_reg, cfg_next;
    logic front_valid_reg, front_valid_next;
    op_t  front_op_reg, front_op_next;

    logic [15:0] len_c;
    logic [15:0] min_len;
    logic [15:0] hdr_bytes;
    logic [31:0] w0, w1, w3;
    logic        is_short;
    logic        accept;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BIG_ENDIAN:    cfg_next.big_endian = cfg_data[0];
                CFG_OFFSET_BYTES:  cfg_next.offset     = cfg_data;
                CFG_FILTER_ENABLE: cfg_next.filter_en  = cfg_data[0];
                CFG_THREAD_SELECT: cfg_next.thread_sel = cfg_data[5:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    assign in_ready = !front_valid_reg || op_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        len_c = (packet_length > 16'(MAX_PACKET_BYTES)) ? 16'(MAX_PACKET_BYTES)
                                                        : packet_length;
        min_len  = VDIF_HDR_BYTES + 16'(cfg_reg.offset);
        is_short = len_c < min_len;
        w0 = cfg_reg.big_endian ? swap32(header_word0) : header_word0;
        w1 = cfg_reg.big_endian ? swap32(header_word1) : header_word1;
        w3 = cfg_reg.big_endian ? swap32(header_word3) : header_word3;
        hdr_bytes = w0[30] ? LEGACY_HDR_BYTES : VDIF_HDR_BYTES;

        front_op_next.sec      = w0[29:0] & SEC_MASK;
        front_op_next.fno      = w1[23:0];
        front_op_next.epoch    = w1[29:24];
        front_op_next.tid      = w3[21:16];
        front_op_next.pay      = len_c - 16'(cfg_reg.offset) - hdr_bytes;
        front_op_next.last_pay = len_c - 16'(cfg_reg.offset) - VDIF_HDR_BYTES;
        if (command)
            front_op_next.kind = OP_TIMEOUT;
        else if (cfg_reg.filter_en && (w3[21:16] != cfg_reg.thread_sel))
            front_op_next.kind = OP_THREAD;
        else
            front_op_next.kind = OP_FRAME;

        // drop short packets here; a timeout always goes through
        if (accept)
            front_valid_next = command || !is_short;
        else if (op_ready)
            front_valid_next = 1'b0;
        else
            front_valid_next = front_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg         <= '0;
            front_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg         <= cfg_next;
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            front_op_reg <= front_op_next;
    end

    assign op_valid = front_valid_reg;
    assign op       = front_op_reg;

endmodule
`default_nettype wire

/* hw/rtl/vssm_queue.sv */
// Two-entry queue of classified items between front and back.
`default_nettype none
module vssm_queue
    import vssm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  op_t       push_op,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output op_t       pop_op
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    op_t mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic push, pop;

    assign push_ready = count_reg != (PTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;
    assign pop_op = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_op;
    end

endmodule
`default_nettype wire

/* hw/rtl/vssm_back.sv */
// Back end: per-second statistics and the new-second result record.
`default_nettype none
module vssm_back
    import vssm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic op_valid,
    output logic      op_ready,
    input  op_t       op,
    input  wire logic adv,
    output logic      rec_valid,
    output rec_t      rec
);

    logic [29:0] prev_sec_reg, prev_sec_next;
    logic [24:0] frame_cnt_reg, frame_cnt_next;
    logic [39:0] byte_cnt_reg, byte_cnt_next;
    logic [23:0] high_frame_reg, high_frame_next;
    logic [5:0]  high_thread_reg, high_thread_next;
    logic        rec_valid_reg, rec_valid_next;
    rec_t        rec_reg, rec_next;

    logic [40:0] byte_sum;
    logic [39:0] byte_sat;
    logic [23:0] hf_new;
    logic [24:0] fc_new;
    logic [5:0]  ht_new;
    logic        pop;

    assign op_ready = adv;
    assign pop = op_valid && adv;

    always_comb
    begin
        byte_sum = {1'b0, byte_cnt_reg} + 41'(op.pay);
        byte_sat = byte_sum[40] ? BCNT_MAX : byte_sum[39:0];
        hf_new   = (op.fno > high_frame_reg) ? op.fno : high_frame_reg;
        fc_new   = (frame_cnt_reg != FCNT_MAX) ? frame_cnt_reg + 1'b1 : frame_cnt_reg;
        ht_new   = (op.tid > high_thread_reg) ? op.tid : high_thread_reg;

        prev_sec_next    = prev_sec_reg;
        frame_cnt_next   = frame_cnt_reg;
        byte_cnt_next    = byte_cnt_reg;
        high_frame_next  = high_frame_reg;
        high_thread_next = high_thread_reg;
        rec_valid_next   = adv ? 1'b0 : rec_valid_reg;

        rec_next            = '0;
        rec_next.sec        = op.sec;
        rec_next.epoch      = op.epoch;
        rec_next.fno        = op.fno;
        rec_next.frames     = fc_new;
        rec_next.max_fno_p1 = {1'b0, hf_new} + 25'd1;
        rec_next.threads    = ht_new;
        rec_next.bytes      = byte_sat;
        rec_next.last_pay   = op.last_pay;

        if (pop)
        begin
            unique case (op.kind)
                OP_TIMEOUT:
                begin
                    byte_cnt_next   = '0;
                    high_frame_next = '0;
                end
                OP_THREAD:
                begin
                    high_thread_next = ht_new;
                end
                OP_FRAME:
                begin
                    high_thread_next = ht_new;
                    if (op.sec != prev_sec_reg)
                    begin
                        // new second: emit, then restart the statistics
                        rec_valid_next  = 1'b1;
                        prev_sec_next   = op.sec;
                        frame_cnt_next  = '0;
                        byte_cnt_next   = '0;
                        high_frame_next = '0;
                    end
                    else
                    begin
                        frame_cnt_next  = fc_new;
                        byte_cnt_next   = byte_sat;
                        high_frame_next = hf_new;
                    end
                end
                default:
                begin
                    high_thread_next = high_thread_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sec_reg    <= '0;
            frame_cnt_reg   <= '0;
            byte_cnt_reg    <= '0;
            high_frame_reg  <= '0;
            high_thread_reg <= 6'd1;
            rec_valid_reg   <= 1'b0;
        end
        else
        begin
            prev_sec_reg    <= prev_sec_next;
            frame_cnt_reg   <= frame_cnt_next;
            byte_cnt_reg    <= byte_cnt_next;
            high_frame_reg  <= high_frame_next;
            high_thread_reg <= high_thread_next;
            rec_valid_reg   <= rec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rec_reg <= rec_next;
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

endmodule
`default_nettype wire

/* hw/rtl/vssm_timecvt.sv */
// Timestamp pipeline: seconds field to day of year, hour, minute, second.
`default_nettype none
module vssm_timecvt
    import vssm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic rec_valid,
    input  rec_t      rec,
    output logic      adv,
    output logic      out_valid,
    input  wire logic out_ready,
    output rec_t      out_rec
);

    localparam int unsigned STAGES = 6;

    logic [STAGES:1] v_reg;
    rec_t st_reg [1:STAGES];
    rec_t st_next [1:STAGES];

    logic [46:0] p_day;
    logic [30:0] day_secs;
    logic [29:0] rem_day_w;
    logic [26:0] p_hour;
    logic [16:0] hour_secs;
    logic [16:0] rem_hour_w;
    logic [20:0] p_min;
    logic [11:0] min_secs;
    logic [11:0] ss_w;
    logic [13:0] doy_adj;

    // whole pipeline moves together; stall when the last stage is held
    assign adv       = !v_reg[STAGES] || out_ready;
    assign out_valid = v_reg[STAGES];
    assign out_rec   = st_reg[STAGES];

    always_comb
    begin
        st_next[1] = rec;
        p_day = 47'(rec.sec[29:7]) * 47'(DAY_RECIP);
        st_next[1].days = p_day[DAY_SHIFT +: 14];

        st_next[2] = st_reg[1];
        day_secs  = 31'(st_reg[1].days) * 31'(SEC_PER_DAY);
        rem_day_w = st_reg[1].sec - day_secs[29:0];
        st_next[2].rem_day = rem_day_w[16:0];
        // odd epoch starts on July 1
        if (st_reg[1].epoch[0])
            doy_adj = (st_reg[1].epoch[2:1] == 2'd0) ? HALF_LEAP_YEAR_DAYS : HALF_YEAR_DAYS;
        else
            doy_adj = '0;
        st_next[2].doy = st_reg[1].days + 14'd1 + doy_adj;

        st_next[3] = st_reg[2];
        p_hour = 27'(st_reg[2].rem_day[16:4]) * 27'(HOUR_RECIP);
        st_next[3].hh = p_hour[HOUR_SHIFT +: 5];

        st_next[4] = st_reg[3];
        hour_secs  = 17'(st_reg[3].hh) * 17'(SEC_PER_HOUR);
        rem_hour_w = st_reg[3].rem_day - hour_secs;
        st_next[4].rem_hour = rem_hour_w[11:0];

        st_next[5] = st_reg[4];
        p_min = 21'(st_reg[4].rem_hour[11:2]) * 21'(MIN_RECIP);
        st_next[5].mm = p_min[MIN_SHIFT +: 6];

        st_next[6] = st_reg[5];
        min_secs = 12'(st_reg[5].mm) * 12'(SEC_PER_MIN);
        ss_w     = st_reg[5].rem_hour - min_secs;
        st_next[6].ss = ss_w[5:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[STAGES-1:1], rec_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 1; i <= STAGES; i++)
                st_reg[i] <= st_next[i];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/vdif_stream_second_monitor_unit.sv */
// Top level of the VDIF stream second monitor.
// Usage:
//   Input channel (in_valid/in_ready): one item per packet header, or a
//   receive timeout when command is 1. Short packets are dropped in the
//   front end; timeouts clear the byte count and highest frame number.
//   Output channel (out_valid/out_ready): one statistics item each time the
//   seconds field changes, with the timestamp split into calendar fields.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): four
//   registers, always ready; write them only while the block is idle.
// Throughput: one item per cycle unless the timestamp pipeline stalls. The front
//   register, a two-entry queue and the statistics stage each take an item per cycle.
// Path: an item accepted into the front register passes through the queue to
//   the statistics stage; a result then runs through the 6-stage timestamp
//   pipeline before out_valid rises. The pipeline length is set by the three
//   reciprocal multiplies, each followed by a multiply-and-subtract stage.
// Reset: all statistics clear, highest thread starts at 1, configuration registers clear.
// Stall: when out_ready is low with a result waiting, the whole timestamp pipeline and
//   statistics stage hold; the queue and front register fill, then in_ready drops.
`default_nettype none
module vdif_stream_second_monitor_unit
    import vssm_pkg::*;
#(
    parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [9:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic [15:0] packet_length,
    input  wire logic [31:0] header_word0,
    input  wire logic [31:0] header_word1,
    input  wire logic [31:0] header_word3,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [23:0]      frame_number,
    output logic [10:0]      year,
    output logic [13:0]      day_of_year,
    output logic [4:0]       hour,
    output logic [5:0]       minute,
    output logic [5:0]       second,
    output logic [24:0]      frames_counted,
    output logic [24:0]      max_frame_plus_one,
    output logic [5:0]       threads_seen,
    output logic [39:0]      payload_bytes_counted,
    output logic [15:0]      last_payload_bytes
);

    logic f_valid, f_ready;
    op_t  f_op;
    logic q_valid, q_ready;
    op_t  q_op;
    logic adv;
    logic r_valid;
    rec_t r_rec;
    rec_t o_rec;

    vssm_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .packet_length(packet_length),
        .header_word0 (header_word0),
        .header_word1 (header_word1),
        .header_word3 (header_word3),
        .op_valid     (f_valid),
        .op_ready     (f_ready),
        .op           (f_op)
    );

    vssm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(f_valid),
        .push_ready(f_ready),
        .push_op   (f_op),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_op    (q_op)
    );

    vssm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (q_valid),
        .op_ready (q_ready),
        .op       (q_op),
        .adv      (adv),
        .rec_valid(r_valid),
        .rec      (r_rec)
    );

    vssm_timecvt u_timecvt (
        .clk      (clk),
        .rst_n    (rst_n),
        .rec_valid(r_valid),
        .rec      (r_rec),
        .adv      (adv),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_rec  (o_rec)
    );

    assign frame_number          = o_rec.fno;
    assign year                  = BASE_YEAR + 11'(o_rec.epoch[5:1]);
    assign day_of_year           = o_rec.doy;
    assign hour                  = o_rec.hh;
    assign minute                = o_rec.mm;
    assign second                = o_rec.ss;
    assign frames_counted        = o_rec.frames;
    assign max_frame_plus_one    = o_rec.max_fno_p1;
    assign threads_seen          = o_rec.threads;
    assign payload_bytes_counted = o_rec.bytes;
    assign last_payload_bytes    = o_rec.last_pay;

endmodule
`default_nettype wire

/* tb/vdif_stream_second_monitor_unit_tb.sv */
// Self-checking testbench for the VDIF stream second monitor unit.
`default_nettype none
module vdif_stream_second_monitor_unit_tb
    import vssm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_PACKET  = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [23:0] frame_number;
        logic [10:0] year;
        logic [13:0] doy;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [24:0] frames;
        logic [24:0] max_p1;
        logic [5:0]  threads;
        logic [39:0] bytes;
        logic [15:0] last_bytes;
    } second_report_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t      kind;
        logic [1:0]     reg_idx;
        logic [9:0]     reg_val;
        logic           cmd;
        logic [15:0]    len;
        logic [31:0]    w0;
        logic [31:0]    w1;
        logic [31:0]    w3;
        logic           typed;
        second_report_t want;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_BIG_ENDIAN;
    logic [9:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        command = CMD_PACKET;
    logic [15:0] packet_length = '0;
    logic [31:0] header_word0 = '0;
    logic [31:0] header_word1 = '0;
    logic [31:0] header_word3 = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [23:0] frame_number;
    logic [10:0] year;
    logic [13:0] day_of_year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [24:0] frames_counted;
    logic [24:0] max_frame_plus_one;
    logic [5:0]  threads_seen;
    logic [39:0] payload_bytes_counted;
    logic [15:0] last_payload_bytes;

    vdif_stream_second_monitor_unit uut (.*);

    always #5 clk = ~clk;

    // Predictor copy of registers and per-second state
    logic        cfg_swap = 1'b0;
    logic [9:0]  cfg_offset = '0;
    logic        cfg_filter = 1'b0;
    logic [5:0]  cfg_thread = '0;
    logic [29:0] last_sec = '0;
    logic [24:0] frame_tally = '0;
    logic [39:0] byte_tally = '0;
    logic [23:0] top_frame = '0;
    logic [5:0]  top_thread = 6'd1;

    // Well-formed stream generator state
    logic [29:0] stream_sec = 30'd100;
    logic [5:0]  stream_epoch = '0;
    logic [23:0] stream_fno = '0;

    second_report_t pending_reports[$];
    int errors = 0;
    int items_sent = 0;
    int hold_left = 0;
    bit held_once = 1'b0;
    bit calm = 1'b0;

    function automatic logic [31:0] byte_reverse(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic bit predict_second_report(input logic cmd, input logic [15:0] len_in,
            input logic [31:0] w0_in, input logic [31:0] w1_in, input logic [31:0] w3_in,
            output second_report_t rep);
        int unsigned len, sec, days, rem, yr, doy, hdr;
        logic [31:0] w0, w1, w3;
        logic [23:0] fno;
        logic [5:0]  tid, epoch;
        logic [40:0] sum;
        rep = '0;
        if (cmd == CMD_TIMEOUT)
        begin
            byte_tally = '0;
            top_frame = '0;
            return 1'b0;
        end
        len = 32'(len_in);
        if (len > MAX_PACKET_BYTES_DEF)
            len = MAX_PACKET_BYTES_DEF;
        if (len < 32 + 32'(cfg_offset))
            return 1'b0;
        w0 = cfg_swap ? byte_reverse(w0_in) : w0_in;
        w1 = cfg_swap ? byte_reverse(w1_in) : w1_in;
        w3 = cfg_swap ? byte_reverse(w3_in) : w3_in;
        sec = 32'(w0[29:0]);
        fno = w1[23:0];
        epoch = w1[29:24];
        tid = w3[21:16];
        if (tid > top_thread)
            top_thread = tid;
        if (cfg_filter && tid != cfg_thread)
            return 1'b0;
        // legacy headers are 16 bytes long
        hdr = w0[30] ? 16 : 32;
        sum = 41'(byte_tally) + 41'(len - 32'(cfg_offset) - hdr);
        byte_tally = (sum > 41'(BCNT_MAX)) ? BCNT_MAX : sum[39:0];
        if (fno > top_frame)
            top_frame = fno;
        if (frame_tally != FCNT_MAX)
            frame_tally = frame_tally + 25'd1;
        if (sec == 32'(last_sec))
            return 1'b0;
        yr = 32'(BASE_YEAR) + 32'(epoch[5:1]);
        days = sec / 86400;
        rem = sec % 86400;
        doy = days + 1;
        // odd epochs start on July 1
        if (epoch[0])
            doy += (yr % 4 == 0) ? 182 : 181;
        rep.frame_number = fno;
        rep.year = 11'(yr);
        rep.doy = 14'(doy);
        rep.hour = 5'(rem / 3600);
        rep.minute = 6'((rem % 3600) / 60);
        rep.second = 6'(rem % 60);
        rep.frames = frame_tally;
        rep.max_p1 = {1'b0, top_frame} + 25'd1;
        rep.threads = top_thread;
        rep.bytes = byte_tally;
        rep.last_bytes = 16'(len - 32'(cfg_offset) - 32);
        frame_tally = '0;
        byte_tally = '0;
        top_frame = '0;
        last_sec = 30'(sec);
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [39:0] want, input logic [39:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Receiver: random stalls, one long hold-off, and the result check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual frame_number %0d",
                             $time, frame_number);
                    errors++;
                end
                else
                begin
                    second_report_t want;
                    want = pending_reports.pop_front();
                    check_field("frame_number", 40'(want.frame_number), 40'(frame_number));
                    check_field("year", 40'(want.year), 40'(year));
                    check_field("day_of_year", 40'(want.doy), 40'(day_of_year));
                    check_field("hour", 40'(want.hour), 40'(hour));
                    check_field("minute", 40'(want.minute), 40'(minute));
                    check_field("second", 40'(want.second), 40'(second));
                    check_field("frames_counted", 40'(want.frames), 40'(frames_counted));
                    check_field("max_frame_plus_one", 40'(want.max_p1),
                                40'(max_frame_plus_one));
                    check_field("threads_seen", 40'(want.threads), 40'(threads_seen));
                    check_field("payload_bytes_counted", want.bytes, payload_bytes_counted);
                    check_field("last_payload_bytes", 40'(want.last_bytes),
                                40'(last_payload_bytes));
                end
            end
            if (!held_once && items_sent >= 900)
            begin
                held_once = 1'b1;
                hold_left = 400;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(99) >= 16);
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [15:0] len, input logic [31:0] w0,
            input logic [31:0] w1, input logic [31:0] w3, input bit typed,
            input second_report_t want);
        second_report_t rep;
        bit has_rep;
        if (!calm && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        packet_length <= len;
        header_word0 <= w0;
        header_word1 <= w1;
        header_word3 <= w3;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        has_rep = predict_second_report(cmd, len, w0, w1, w3, rep);
        if (typed)
            pending_reports.push_back(want);
        else if (has_rep)
            pending_reports.push_back(rep);
    endtask

    // Drop valid and let every result and any in-flight dropped item drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0 || hold_left != 0)
            @(posedge clk);
        repeat (32) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_BIG_ENDIAN:    cfg_swap = val[0];
            CFG_OFFSET_BYTES:  cfg_offset = val;
            CFG_FILTER_ENABLE: cfg_filter = val[0];
            CFG_THREAD_SELECT: cfg_thread = val[5:0];
            default: ;
        endcase
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic sw, input logic [9:0] off, input logic filt,
            input logic [5:0] sel);
        wait_idle();
        write_reg(CFG_BIG_ENDIAN, {9'd0, sw}, 1'b0);
        write_reg(CFG_OFFSET_BYTES, off, 1'b0);
        write_reg(CFG_FILTER_ENABLE, {9'd0, filt}, 1'b0);
        write_reg(CFG_THREAD_SELECT, {4'd0, sel}, 1'b1);
    endtask

    task automatic run_phase(input int n_items, input bit pause_midway);
        int k, pick;
        int unsigned min_len;
        logic cmd;
        logic [15:0] len;
        logic [31:0] w0, w1, w3;
        min_len = 32'(cfg_offset) + 32;
        for (k = 0; k < n_items; k++)
        begin
            if (pause_midway && k == n_items / 2)
                wait_idle();
            pick = $urandom_range(99);
            cmd = CMD_PACKET;
            len = 16'($urandom);
            w0 = $urandom;
            w1 = $urandom;
            w3 = $urandom;
            if (pick < 5)
            begin
                cmd = CMD_TIMEOUT;
            end
            else if (pick < 10)
            begin
                len = 16'($urandom_range(min_len - 1, 0));
            end
            else if (pick >= 14)
            begin
                // well-formed frame of the running stream
                if ($urandom_range(7) == 0)
                    stream_sec = stream_sec + 30'd1;
                if ($urandom_range(49) == 0)
                begin
                    stream_sec = 30'($urandom);
                    stream_epoch = 6'($urandom);
                end
                if ($urandom_range(19) == 0)
                    stream_fno = 24'($urandom);
                w0 = {w0[31], ($urandom_range(4) == 0), stream_sec};
                w1 = {w1[31:30], stream_epoch, stream_fno};
                stream_fno = stream_fno + 24'd1;
                if (cfg_filter && $urandom_range(3) != 0)
                    w3[21:16] = cfg_thread;
                else
                    w3[21:16] = 6'($urandom_range(63));
                if ($urandom_range(9) == 0)
                    len = 16'($urandom_range(65535, min_len));
                else
                    len = 16'(min_len + $urandom_range(1500));
                if (cfg_swap)
                begin
                    w0 = byte_reverse(w0);
                    w1 = byte_reverse(w1);
                    w3 = byte_reverse(w3);
                end
            end
            send_item(cmd, len, w0, w1, w3, 1'b0, '0);
        end
    endtask

    function automatic script_row_t pkt_row(input logic cmd, input logic [15:0] len,
            input logic [31:0] w0, input logic [31:0] w1, input logic [31:0] w3);
        script_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.cmd = cmd;
        r.len = len;
        r.w0 = w0;
        r.w1 = w1;
        r.w3 = w3;
        return r;
    endfunction

    function automatic script_row_t reg_row(input logic [1:0] idx, input logic [9:0] val);
        script_row_t r;
        r = '0;
        r.kind = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    initial
    begin
        script_row_t script[$];
        script_row_t r;
        int p;

        // first frame after reset opens second 1
        r = pkt_row(CMD_PACKET, 16'd100, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
        r.typed = 1'b1;
        r.want = '{24'd0, 11'd2000, 14'd1, 5'd0, 6'd0, 6'd1, 25'd1, 25'd1, 6'd1,
                   40'd68, 16'd68};
        script.push_back(r);
        // all-ones seconds field, header words 1 and 3 all ones, oversized packet
        r = pkt_row(CMD_PACKET, 16'hFFFF, 32'hBFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        r.typed = 1'b1;
        r.want = '{24'hFF_FFFF, 11'd2031, 14'd12609, 5'd13, 6'd37, 6'd3, 25'd1,
                   25'h100_0000, 6'd63, 40'd65475, 16'd65475};
        script.push_back(r);
        script.push_back(pkt_row(CMD_PACKET, 16'd32, 32'h3FFF_FFFF, 32'h0000_0005, 32'h0));
        script.push_back(pkt_row(CMD_TIMEOUT, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF));
        script.push_back(pkt_row(CMD_PACKET, 16'd31, 32'h0000_0002, 32'h0, 32'h0));
        script.push_back(pkt_row(CMD_PACKET, 16'd200, 32'h7FFF_FFFF, 32'h0000_0003,
                                 32'h0005_0000));
        script.push_back(pkt_row(CMD_PACKET, 16'd64, 32'h0, 32'h0100_0007, 32'h0));
        script.push_back(pkt_row(CMD_PACKET, 16'd1000, 32'h0001_517F, 32'h0300_0009, 32'h0));
        script.push_back(pkt_row(CMD_PACKET, 16'd0, 32'h0000_0004, 32'h0, 32'h0));
        script.push_back(reg_row(CFG_OFFSET_BYTES, 10'd1023));
        script.push_back(pkt_row(CMD_PACKET, 16'd1054, 32'h0000_0005, 32'h0, 32'h0));
        script.push_back(pkt_row(CMD_PACKET, 16'd1055, 32'h0000_0005, 32'h0, 32'h0));
        script.push_back(pkt_row(CMD_PACKET, 16'hFFFF, 32'h0000_0006, 32'h0, 32'h0));
        script.push_back(reg_row(CFG_OFFSET_BYTES, 10'd0));
        script.push_back(reg_row(CFG_BIG_ENDIAN, 10'd1));
        script.push_back(pkt_row(CMD_PACKET, 16'd500, 32'h7856_3412, 32'h0B00_0000,
                                 32'h0000_0200));
        script.push_back(reg_row(CFG_FILTER_ENABLE, 10'd1));
        script.push_back(reg_row(CFG_THREAD_SELECT, 10'd5));
        // other thread: only its thread number is counted, then the selected one
        script.push_back(pkt_row(CMD_PACKET, 16'd300, 32'h0700_0000, 32'h0, 32'h0000_0700));
        script.push_back(pkt_row(CMD_PACKET, 16'd300, 32'h0800_0000, 32'h0, 32'h0000_0500));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_REG)
            begin
                wait_idle();
                write_reg(script[i].reg_idx, script[i].reg_val, 1'b1);
            end
            else
            begin
                send_item(script[i].cmd, script[i].len, script[i].w0, script[i].w1,
                          script[i].w3, script[i].typed, script[i].want);
            end
        end

        for (p = 0; p < 8; p++)
        begin
            if (p == 0)
                set_config(1'b0, 10'd0, 1'b0, 6'd0);
            else if (p == 1)
                set_config(1'b1, 10'd1023, 1'b1, 6'd63);
            else
                set_config(1'($urandom_range(1)),
                           10'(($urandom_range(3) == 0) ? $urandom_range(1023)
                                                        : $urandom_range(64)),
                           ($urandom_range(3) == 0), 6'($urandom_range(63)));
            calm = (p == 2);
            run_phase(200, p == 4);
        end
        calm = 1'b0;

        wait_idle();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("%0t: timeout with %0d results outstanding", $time, pending_reports.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
